// File: src/edit_distance_one_check_assert.svh
// assertion macros shared by the edit distance checker
`ifndef EDIT_DISTANCE_ONE_CHECK_ASSERT_SVH
`define EDIT_DISTANCE_ONE_CHECK_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EOC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("eoc check failed");

// next-cycle implication, disabled during reset
`define EOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("eoc check failed");

`endif

// File: src/eoc_pkg.sv
// shared types and constants of the edit distance checker
package eoc_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int CHAR_W      = 8;
	localparam int ACTION_W    = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FIRST  = 2'd0,
		ACT_SECOND = 2'd1,
		ACT_CMP    = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// per-cell control
	typedef struct packed {
		logic shift;
		logic wr_first;
		logic wr_second;
	} cell_ctl_t;

	// evaluator control
	typedef struct packed {
		logic start;
		logic step;
	} eval_ctl_t;

	// evaluator status back to the sequencer
	typedef struct packed {
		logic done;
		logic within_one_edit;
		logic within_one_edit_or_swap;
		logic single_substitution;
		logic overflow;
	} eval_status_t;

endpackage

// File: src/eoc_cell.sv
// one character position of both strings, shifts toward the head on compare
module eoc_cell (
	input  logic                          clk,
	input  eoc_pkg::cell_ctl_t            ctl,
	input  logic [eoc_pkg::CHAR_W-1:0]    char_code,
	input  logic [eoc_pkg::CHAR_W-1:0]    next_first,
	input  logic [eoc_pkg::CHAR_W-1:0]    next_second,
	output logic [eoc_pkg::CHAR_W-1:0]    first_char,
	output logic [eoc_pkg::CHAR_W-1:0]    second_char
);

	logic [eoc_pkg::CHAR_W-1:0] first_q;
	logic [eoc_pkg::CHAR_W-1:0] second_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			first_q  <= next_first;
			second_q <= next_second;
		end else begin
			if (ctl.wr_first) begin
				first_q <= char_code;
			end
			if (ctl.wr_second) begin
				second_q <= char_code;
			end
		end
	end

	assign first_char  = first_q;
	assign second_char = second_q;

endmodule

// File: src/eoc_eval.sv
// head-of-chain evaluator: walks positions as the cells shift past it
module eoc_eval #(
	parameter int MaxLen = eoc_pkg::MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  eoc_pkg::eval_ctl_t                  ctl,
	input  logic [$clog2(MaxLen+1)-1:0]         len_first,
	input  logic [$clog2(MaxLen+1)-1:0]         len_second,
	input  logic                                overflow_in,
	input  logic [eoc_pkg::CHAR_W-1:0]          a0,
	input  logic [eoc_pkg::CHAR_W-1:0]          a1,
	input  logic [eoc_pkg::CHAR_W-1:0]          b0,
	input  logic [eoc_pkg::CHAR_W-1:0]          b1,
	output eoc_pkg::eval_status_t               status
);

	localparam int LW = $clog2(MaxLen + 1);

	logic [LW-1:0] pos_q;
	logic [LW-1:0] lf_q;
	logic [LW-1:0] ls_q;
	logic [LW-1:0] last_q;
	logic [1:0]    ndiff_q;
	logic          cand_q;
	logic          pre_f_q;
	logic          ok_f_q;
	logic          pre_s_q;
	logic          ok_s_q;
	logic          ovf_q;

	logic eq;
	logic in_f;
	logic in_s;
	logic len_eq;
	logic f_long;
	logic s_long;
	logic sub;
	logic swap;
	logic edit;

	assign eq   = (a0 == b0);
	// first string longer: shorter is second, so mask by its length
	assign in_f = (pos_q < ls_q);
	assign in_s = (pos_q < lf_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			lf_q    <= '0;
			ls_q    <= '0;
			last_q  <= '0;
			ndiff_q <= '0;
			cand_q  <= 1'b0;
			pre_f_q <= 1'b1;
			ok_f_q  <= 1'b1;
			pre_s_q <= 1'b1;
			ok_s_q  <= 1'b1;
			ovf_q   <= 1'b0;
		end else if (ctl.start) begin
			pos_q   <= '0;
			lf_q    <= len_first;
			ls_q    <= len_second;
			last_q  <= (len_first > len_second) ? len_first : len_second;
			ndiff_q <= '0;
			cand_q  <= 1'b0;
			pre_f_q <= 1'b1;
			ok_f_q  <= 1'b1;
			pre_s_q <= 1'b1;
			ok_s_q  <= 1'b1;
			ovf_q   <= overflow_in;
		end else if (ctl.step) begin
			pos_q <= pos_q + LW'(1);
			if (!eq && ndiff_q != 2'd3) begin
				ndiff_q <= ndiff_q + 2'd1;
			end
			// cross check of a possible adjacent swap at the first mismatch
			if (!eq && ndiff_q == 2'd0) begin
				cand_q <= (a0 == b1) && (a1 == b0);
			end
			if (in_f && !(pre_f_q && eq)) begin
				pre_f_q <= 1'b0;
				ok_f_q  <= ok_f_q & (a1 == b0);
			end
			if (in_s && !(pre_s_q && eq)) begin
				pre_s_q <= 1'b0;
				ok_s_q  <= ok_s_q & (b1 == a0);
			end
		end
	end

	assign len_eq = (lf_q == ls_q);
	assign f_long = ({1'b0, lf_q} == ({1'b0, ls_q} + (LW+1)'(1)));
	assign s_long = ({1'b0, ls_q} == ({1'b0, lf_q} + (LW+1)'(1)));
	assign sub    = len_eq && (ndiff_q == 2'd1);
	assign swap   = len_eq && (ndiff_q == 2'd2) && cand_q;
	assign edit   = sub || (f_long && ok_f_q) || (s_long && ok_s_q);

	assign status.done                    = (pos_q == last_q);
	assign status.within_one_edit         = edit;
	assign status.within_one_edit_or_swap = edit || swap;
	assign status.single_substitution     = sub;
	assign status.overflow                = ovf_q;

endmodule

// File: src/edit_distance_one_check.sv
// top level of the one-edit-away string checker
//
// usage:
//  - input channel s_axis: tuser[1:0] carries the action, tdata[7:0] the byte.
//    action 0 appends the byte to the first string, 1 to the second string,
//    2 compares the two strings and clears them, 3 is taken and ignored
//  - output channel m_axis: one item per compare, tdata bits from the lowest:
//    within_one_edit, within_one_edit_or_swap, single_substitution, overflow
//  - both strings live in a row of MaxLen cells, one byte pair per cell.
//    an append writes the cell at the current length, one item per cycle
//    while idle. bytes past MaxLen are dropped and set the overflow flag
//  - a compare shifts the row toward the head one cell per cycle; an
//    evaluator at the head looks at cells 0 and 1 and folds the result.
//    the compare holds the input until the walk over the longer string ends
//    and its result moves into the output register, which drives m_axis
//  - the result sits in an output register; appends for the next compare
//    proceed while it waits. a further compare finishes its walk and then
//    holds until the receiver frees the register
//  - reset clears lengths, overflow and the output valid; byte cells keep
//    whatever they held, they are only read below the written length
module edit_distance_one_check #(
	parameter int MaxLen = eoc_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // char_code
	input  logic [1:0] s_axis_tuser,   // action
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // within_one_edit, within_one_edit_or_swap,
	                                   // single_substitution, overflow, 4 zero bits
);

	`include "edit_distance_one_check_assert.svh"

	localparam int LW = $clog2(MaxLen + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t        state_q;
	logic [LW-1:0] first_len_q;
	logic [LW-1:0] second_len_q;
	logic          ovf_q;
	logic          out_valid_q;
	logic [3:0]    out_flags_q;

	logic accept;
	logic is_first;
	logic is_second;
	logic is_cmp;
	logic out_free;
	logic out_load;
	logic scan_step;

	eoc_pkg::eval_ctl_t    ev_ctl;
	eoc_pkg::eval_status_t ev_status;

	// byte rows, the extra slot past the last cell feeds zeros on shift
	logic [eoc_pkg::CHAR_W-1:0] first_row  [0:MaxLen];
	logic [eoc_pkg::CHAR_W-1:0] second_row [0:MaxLen];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_first      = accept && (s_axis_tuser == eoc_pkg::ACT_FIRST);
	assign is_second     = accept && (s_axis_tuser == eoc_pkg::ACT_SECOND);
	assign is_cmp        = accept && (s_axis_tuser == eoc_pkg::ACT_CMP);
	assign out_free      = !out_valid_q || m_axis_tready;
	// finished walk moves into the output register
	assign out_load      = (state_q == ST_SCAN) && ev_status.done && out_free;
	assign scan_step     = (state_q == ST_SCAN) && !ev_status.done;

	assign ev_ctl.start = is_cmp;
	assign ev_ctl.step  = scan_step;

	assign first_row[MaxLen]  = '0;
	assign second_row[MaxLen] = '0;

	// row of character cells
	for (genvar i = 0; i < MaxLen; i++) begin : g_cell
		eoc_pkg::cell_ctl_t cell_ctl;

		assign cell_ctl.shift     = scan_step;
		assign cell_ctl.wr_first  = is_first && (first_len_q == LW'(i));
		assign cell_ctl.wr_second = is_second && (second_len_q == LW'(i));

		eoc_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl),
			.char_code   (s_axis_tdata),
			.next_first  (first_row[i+1]),
			.next_second (second_row[i+1]),
			.first_char  (first_row[i]),
			.second_char (second_row[i])
		);
	end

	eoc_eval #(
		.MaxLen (MaxLen)
	) u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ev_ctl),
		.len_first   (first_len_q),
		.len_second  (second_len_q),
		.overflow_in (ovf_q),
		.a0          (first_row[0]),
		.a1          (first_row[1]),
		.b0          (second_row[0]),
		.b1          (second_row[1]),
		.status      (ev_status)
	);

	// sequencer, string lengths and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_flags_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_flags_q <= {ev_status.overflow,
				                ev_status.single_substitution,
				                ev_status.within_one_edit_or_swap,
				                ev_status.within_one_edit};
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_first) begin
						if (first_len_q < LW'(MaxLen)) begin
							first_len_q <= first_len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (is_second) begin
						if (second_len_q < LW'(MaxLen)) begin
							second_len_q <= second_len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					// lengths and overflow go to the evaluator, then clear
					if (is_cmp) begin
						first_len_q  <= '0;
						second_len_q <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_flags_q};

	// a compare blocks the input in the cycle after it is taken
	`EOC_ASSERT_NEXT(a_cmp_blocks_input, clk, arst_n, is_cmp, !s_axis_tready)
	// lengths are cleared for the whole walk
	`EOC_ASSERT_NOW(a_scan_cleared, clk, arst_n, state_q == ST_SCAN,
		first_len_q == '0 && second_len_q == '0 && !ovf_q)
	// lengths stay within the row
	`EOC_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1,
		first_len_q <= LW'(MaxLen) && second_len_q <= LW'(MaxLen))
	// a finished walk with room downstream always presents a result
	`EOC_ASSERT_NEXT(a_result_loaded, clk, arst_n,
		state_q == ST_SCAN && ev_status.done && out_free,
		m_axis_tvalid && s_axis_tready)

endmodule
